@@ sv/cjs_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cjs_pkg
// shared types and codes of the cpu job scheduler tick block
// ----------------------------------------------------------------------------
package cjs_pkg;

   localparam logic [1:0] POLICY_FCFS  = 2'd0;
   localparam logic [1:0] POLICY_SJF   = 2'd1;
   localparam logic [1:0] POLICY_RR    = 2'd2;
   // spare code, runs as first come first served
   localparam logic [1:0] POLICY_SPARE = 2'd3;

   localparam logic [0:0] REG_POLICY  = 1'd0;
   localparam logic [0:0] REG_QUANTUM = 1'd1;

   // packed response word: wait, dropped, rotated, finished pid/valid,
   // queue count, running left/pid/valid
   localparam int RSP_WIDTH = 65;

   // configuration seen by the core
   typedef struct packed {
      logic [1:0] policy;
      logic [7:0] quantum;
   } cfg_type;

endpackage
`default_nettype wire

@@ sv/cjs_stream_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cjs_stream_if
// valid/ready channel carrying a packed payload
// ----------------------------------------------------------------------------
interface cjs_stream_if #(
   parameter int WIDTH = 8
);
   logic             valid;
   logic             ready;
   logic [WIDTH-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ sv/cjs_csr.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cjs_csr
// apb register file holding policy and round robin quantum
// ----------------------------------------------------------------------------
module cjs_csr
   import cjs_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic      [31:0] prdata,
   output logic             pready,
   output cfg_type          cfg
);
   cfg_type cfg_ff, cfg_in;
   logic    wr;

   assign pready = 1'b1;
   assign wr     = psel & penable & pwrite;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr && paddr[1:0] == 2'b00) begin
         unique case (paddr[2])
            REG_POLICY:  cfg_in.policy  = pwdata[1:0];
            REG_QUANTUM: cfg_in.quantum = pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      prdata = 32'd0;
      unique case (paddr[2])
         REG_POLICY:  prdata = {30'd0, cfg_ff.policy};
         REG_QUANTUM: prdata = {24'd0, cfg_ff.quantum};
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{policy: POLICY_FCFS, quantum: 8'd2};
      end else begin
         cfg_ff <= cfg_in;
      end
   end
endmodule
`default_nettype wire

@@ sv/cjs_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cjs_core
// scheduler sequencer around the ready queue memory
// ----------------------------------------------------------------------------
module cjs_core
   import cjs_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16,
   parameter int PID_BITS    = 8,
   parameter int BURST_BITS  = 8
)(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire cfg_type  cfg,
   cjs_stream_if.sink    req,
   cjs_stream_if.source  rsp
);
   localparam int QB = $clog2(QUEUE_DEPTH);
   localparam int CB = $clog2(QUEUE_DEPTH + 1);
   localparam int EW = PID_BITS + BURST_BITS;

   typedef enum logic [2:0] {
      S_IDLE, S_SCAN, S_REMOVE, S_EXPIRE, S_PUSH, S_ARR, S_RUN
   } state_type;

   // queue memory: one write, one read port, registered read
   logic [EW-1:0] mem [QUEUE_DEPTH];
   logic [EW-1:0] rd_ff;
   logic [QB-1:0] raddr;
   logic          we;
   logic [QB-1:0] waddr;
   logic [EW-1:0] wdata;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rd_ff <= mem[raddr];
   end

   state_type             state_ff;
   logic [CB-1:0]         len_ff;
   logic                  busy_ff;
   logic [PID_BITS-1:0]   pid_ff;
   logic [BURST_BITS-1:0] left_ff;
   logic [7:0]            slice_ff;
   logic [31:0]           wait_ff;
   logic [PID_BITS-1:0]   a_pid_ff;
   logic [BURST_BITS-1:0] a_burst_ff;
   logic                  a_valid_ff;
   logic                  fin_ff, rot_ff, drop_ff;
   logic [PID_BITS-1:0]   fin_pid_ff;
   logic [CB-1:0]         idx_ff;     // next read address
   logic [CB-1:0]         pos_ff;     // entry to remove
   logic [BURST_BITS-1:0] best_b_ff;
   logic                  rotp_ff;    // removal is for a rotation
   logic                  rvld_ff;    // rd_ff holds entry idx_ff-1
   logic [PID_BITS-1:0]   old_pid_ff;
   logic [BURST_BITS-1:0] old_left_ff;
   logic                  out_v_ff;
   logic [RSP_WIDTH-1:0]  out_ff;

   logic [BURST_BITS-1:0] rd_burst;
   logic [PID_BITS-1:0]   rd_pid;
   logic [CB-1:0]         ent;
   logic                  last_rd;
   logic                  better;
   logic                  run_go;
   logic [BURST_BITS-1:0] left_nx;
   logic [7:0]            slice_nx;
   logic [31:0]           wsum;
   logic [32:0]           wadd;

   assign rd_pid    = rd_ff[EW-1:BURST_BITS];
   assign rd_burst  = rd_ff[BURST_BITS-1:0];
   assign ent       = idx_ff - CB'(1);
   assign last_rd   = rvld_ff && (idx_ff == len_ff);
   // strict compare keeps the entry nearest the head on ties
   assign better    = (ent == '0) || (rd_burst < best_b_ff);
   assign run_go    = (state_ff == S_RUN) && (!out_v_ff || rsp.ready);
   assign left_nx   = (busy_ff && left_ff != '0) ? left_ff - BURST_BITS'(1) : left_ff;
   assign slice_nx  = (busy_ff && slice_ff != 8'hFF) ? slice_ff + 8'd1 : slice_ff;
   assign req.ready = (state_ff == S_IDLE);
   assign rsp.valid = out_v_ff;
   assign rsp.data  = out_ff;
   assign wadd = {1'b0, wait_ff} + {{(33-CB){1'b0}}, len_ff};
   assign wsum = wadd[32] ? 32'hFFFF_FFFF : wadd[31:0];

   always_comb begin
      raddr = idx_ff[QB-1:0];
      we    = 1'b0;
      waddr = len_ff[QB-1:0];
      wdata = {a_pid_ff, a_burst_ff};
      unique case (state_ff)
         S_REMOVE: begin
            // entries behind the removed one move one place toward the head
            if (rvld_ff && ent != pos_ff) begin
               we    = 1'b1;
               waddr = QB'(ent - CB'(1));
               wdata = rd_ff;
            end
         end
         S_PUSH: begin
            we    = 1'b1;
            wdata = {old_pid_ff, old_left_ff};
         end
         S_ARR: begin
            we = a_valid_ff && busy_ff && (len_ff < CB'(QUEUE_DEPTH));
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         len_ff   <= '0;
         busy_ff  <= 1'b0;
         pid_ff   <= '0;
         left_ff  <= '0;
         slice_ff <= '0;
         wait_ff  <= '0;
         out_v_ff <= 1'b0;
         rvld_ff  <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (req.valid && req.ready) begin
                  a_valid_ff <= req.data[0];
                  a_pid_ff   <= req.data[1 +: PID_BITS];
                  a_burst_ff <= req.data[1 + PID_BITS +: BURST_BITS];
                  rot_ff     <= 1'b0;
                  drop_ff    <= 1'b0;
                  rotp_ff    <= 1'b0;
                  idx_ff     <= '0;
                  pos_ff     <= '0;
                  rvld_ff    <= 1'b0;
                  if (busy_ff && left_ff == '0) begin
                     fin_ff     <= 1'b1;
                     fin_pid_ff <= pid_ff;
                     slice_ff   <= '0;
                     if (len_ff == '0) begin
                        busy_ff  <= 1'b0;
                        pid_ff   <= '0;
                        state_ff <= S_EXPIRE;
                     end else if (cfg.policy == POLICY_SJF) begin
                        state_ff <= S_SCAN;
                     end else begin
                        state_ff <= S_REMOVE;
                     end
                  end else begin
                     fin_ff     <= 1'b0;
                     fin_pid_ff <= '0;
                     state_ff   <= S_EXPIRE;
                  end
               end
            end
            S_SCAN: begin
               if (rvld_ff && better) begin
                  pos_ff    <= ent;
                  best_b_ff <= rd_burst;
               end
               if (last_rd) begin
                  idx_ff   <= better ? ent : pos_ff;
                  rvld_ff  <= 1'b0;
                  state_ff <= S_REMOVE;
               end else begin
                  idx_ff  <= idx_ff + CB'(1);
                  rvld_ff <= 1'b1;
               end
            end
            S_REMOVE: begin
               // first entry read is the one leaving the queue
               if (rvld_ff && ent == pos_ff) begin
                  pid_ff  <= rd_pid;
                  left_ff <= rd_burst;
               end
               if (last_rd) begin
                  rvld_ff  <= 1'b0;
                  len_ff   <= len_ff - CB'(1);
                  state_ff <= rotp_ff ? S_PUSH : S_EXPIRE;
               end else begin
                  idx_ff  <= idx_ff + CB'(1);
                  rvld_ff <= 1'b1;
               end
            end
            S_EXPIRE: begin
               if (cfg.policy == POLICY_RR && busy_ff && slice_ff >= cfg.quantum) begin
                  slice_ff <= '0;
                  if (len_ff != '0) begin
                     rot_ff      <= 1'b1;
                     rotp_ff     <= 1'b1;
                     old_pid_ff  <= pid_ff;
                     old_left_ff <= left_ff;
                     pos_ff      <= '0;
                     idx_ff      <= '0;
                     rvld_ff     <= 1'b0;
                     state_ff    <= S_REMOVE;
                  end else begin
                     state_ff <= S_ARR;
                  end
               end else begin
                  state_ff <= S_ARR;
               end
            end
            S_PUSH: begin
               len_ff   <= len_ff + CB'(1);
               state_ff <= S_ARR;
            end
            S_ARR: begin
               if (a_valid_ff) begin
                  if (!busy_ff) begin
                     busy_ff  <= 1'b1;
                     pid_ff   <= a_pid_ff;
                     left_ff  <= a_burst_ff;
                     slice_ff <= '0;
                  end else if (len_ff < CB'(QUEUE_DEPTH)) begin
                     len_ff <= len_ff + CB'(1);
                  end else begin
                     drop_ff <= 1'b1;
                  end
               end
               state_ff <= S_RUN;
            end
            S_RUN: begin
               // waits here while the previous result is still pending
               if (run_go) begin
                  left_ff  <= left_nx;
                  slice_ff <= slice_nx;
                  wait_ff  <= wsum;
                  out_ff   <= {wsum, drop_ff, rot_ff, 8'(fin_pid_ff), fin_ff,
                               5'(len_ff),
                               busy_ff ? 8'(left_nx) : 8'd0,
                               busy_ff ? 8'(pid_ff) : 8'd0, busy_ff};
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
         if (run_go) begin
            out_v_ff <= 1'b1;
         end else if (rsp.valid && rsp.ready) begin
            out_v_ff <= 1'b0;
         end
      end
   end

`ifndef SYNTHESIS
   a_len: assert property (@(posedge clock) disable iff (reset)
      len_ff <= CB'(QUEUE_DEPTH)) else $error("queue length overflow");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data))
      else $error("result changed while waiting");
   a_idle: assert property (@(posedge clock) disable iff (reset)
      !busy_ff && state_ff == S_IDLE |-> len_ff == '0) else $error("queue without job");
`endif
endmodule
`default_nettype wire

@@ sv/cpu_job_scheduler_tick.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cpu_job_scheduler_tick
// one scheduler tick per request: finish, dispatch, rotate, arrive, run
// ----------------------------------------------------------------------------
// A tick runs the accept, slice check, arrival and run steps plus the walks
// over the ready queue memory, whose single read port serves one entry a
// cycle: each removal walks the queue from the removed entry to the tail (a
// dispatch and a rotation can both happen in one tick), a shortest-job
// dispatch adds a scan of the whole queue and a rotation adds the push to the
// tail. A request is taken in the idle state; a result still waiting on
// rsp_ready holds the next tick at its final run step.
module cpu_job_scheduler_tick
   import cjs_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16,
   parameter int PID_BITS    = 8,
   parameter int BURST_BITS  = 8
)(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_arrival_valid,
   input  wire logic [7:0]  req_arrival_pid,
   input  wire logic [7:0]  req_arrival_burst,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_running_valid,
   output logic [7:0]       rsp_running_pid,
   output logic [7:0]       rsp_running_left,
   output logic [4:0]       rsp_queue_count,
   output logic             rsp_finished_valid,
   output logic [7:0]       rsp_finished_pid,
   output logic             rsp_rotated,
   output logic             rsp_arrival_dropped,
   output logic [31:0]      rsp_total_wait,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   cfg_type cfg;
   cjs_stream_if #(.WIDTH(1 + PID_BITS + BURST_BITS)) req_ch ();
   cjs_stream_if #(.WIDTH(RSP_WIDTH)) rsp_ch ();

   assign req_ch.valid = req_valid;
   assign req_ch.data  = {BURST_BITS'(req_arrival_burst),
                          PID_BITS'(req_arrival_pid), req_arrival_valid};
   assign req_ready    = req_ch.ready;
   assign rsp_valid    = rsp_ch.valid;
   assign rsp_ch.ready = rsp_ready;
   assign {rsp_total_wait, rsp_arrival_dropped, rsp_rotated, rsp_finished_pid,
           rsp_finished_valid, rsp_queue_count, rsp_running_left,
           rsp_running_pid, rsp_running_valid} = rsp_ch.data;

   cjs_csr u_csr (
      .clock, .reset, .psel(csr_psel), .penable(csr_penable), .pwrite(csr_pwrite),
      .paddr(csr_paddr), .pwdata(csr_pwdata), .prdata(csr_prdata),
      .pready(csr_pready), .cfg
   );

   cjs_core #(.QUEUE_DEPTH(QUEUE_DEPTH), .PID_BITS(PID_BITS), .BURST_BITS(BURST_BITS))
   u_core (.clock, .reset, .cfg, .req(req_ch), .rsp(rsp_ch));
endmodule
`default_nettype wire
